[rtl/lfu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by the top level.
package lfu_pkg;

    localparam int CFG_W   = 4;
    localparam int SLOT_W  = 3;
    localparam int FAULT_W = 32;

    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [FAULT_W-1:0] t_fault;

    localparam t_cfg   CFG_RESET = t_cfg'(8);
    localparam t_fault FAULT_MAX = '1;

endpackage

[rtl/lfu_match.sv]
`timescale 1ns / 1ps
// Parallel tag compare over all frames with lowest-index priority.
// Depends on nothing; instantiated by lfu_page_replacement.
module lfu_match #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int IDX_W      = 3
) (
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [PAGE_BITS-1:0]  i_pages [MAX_FRAMES],
    input  logic [MAX_FRAMES-1:0] i_live,
    output logic                  o_hit,
    output logic [IDX_W-1:0]      o_idx
);

    logic [MAX_FRAMES-1:0] match_vec;
    logic [MAX_FRAMES-1:0] first_vec;

    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            match_vec[k] = i_live[k] && (i_pages[k] == i_page);
        end
        // isolate the lowest set bit
        first_vec = match_vec & (~match_vec + MAX_FRAMES'(1));
        o_hit     = |match_vec;
        o_idx     = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (first_vec[k]) begin
                o_idx = o_idx | IDX_W'(k);
            end
        end
    end

endmodule

[rtl/lfu_min_sel.sv]
`timescale 1ns / 1ps
// Balanced compare tree picking the active frame with the smallest use count,
// lowest index on ties. Depends on nothing; instantiated by the top level.
module lfu_min_sel #(
    parameter int MAX_FRAMES = 8,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 3
) (
    input  logic [COUNT_BITS-1:0] i_counts [MAX_FRAMES],
    input  logic [MAX_FRAMES-1:0] i_active,
    output logic [IDX_W-1:0]      o_idx
);

    localparam int LEVELS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 0;
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic                  nd_act [NODES];
    logic [COUNT_BITS-1:0] nd_cnt [NODES];
    logic [IDX_W-1:0]      nd_idx [NODES];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < MAX_FRAMES) begin : g_real
                assign nd_act[LEAVES-1+g] = i_active[g];
                assign nd_cnt[LEAVES-1+g] = i_counts[g];
                assign nd_idx[LEAVES-1+g] = IDX_W'(g);
            end else begin : g_pad
                assign nd_act[LEAVES-1+g] = 1'b0;
                assign nd_cnt[LEAVES-1+g] = '0;
                assign nd_idx[LEAVES-1+g] = '0;
            end
        end
        for (g = 0; g < LEAVES - 1; g++) begin : g_node
            logic take_left;
            // left child holds the lower indices, so it wins ties
            assign take_left = nd_act[2*g+1] &&
                               (!nd_act[2*g+2] || (nd_cnt[2*g+1] <= nd_cnt[2*g+2]));
            assign nd_act[g] = nd_act[2*g+1] | nd_act[2*g+2];
            assign nd_cnt[g] = take_left ? nd_cnt[2*g+1] : nd_cnt[2*g+2];
            assign nd_idx[g] = take_left ? nd_idx[2*g+1] : nd_idx[2*g+2];
        end
    endgenerate

    assign o_idx = nd_idx[0];

endmodule

[rtl/lfu_page_replacement.sv]
`timescale 1ns / 1ps
// Top level of the LFU page replacement block: frame state, handshakes, result register.
// Depends on lfu_pkg, lfu_match and lfu_min_sel.
//
// Usage:
//   Input channel  : i_in_valid / o_in_stall carry one page request (i_page) per transfer.
//   Output channel : o_out_valid / i_out_stall carry one result per request: hit flag,
//                    frame slot, evicted page (with its valid flag) and running fault count.
//   Config channel : i_cfg_valid / o_cfg_ready carry frames_in_use (i_cfg_data); the port is
//                    always ready. Write it only while no request is in flight.
//   Request path: an accepted request is captured in the input register, then goes through
//   one pass of compare, min-select and update into the result register, from which it
//   transfers out.
//   Throughput: one request per cycle while i_out_stall is low. The frame state is updated
//   at the same edge the result is registered, so the next request sees it with no bubble;
//   the combinational path through the tag compare and the use-count min tree sets this rate.
//   Reset (synchronous, active low): all frames empty with count 0, fault count 0,
//   frames_in_use 8, both pipeline registers empty.
//   Receiver stall: the result register holds; a request waiting in the input register
//   holds too and o_in_stall rises, so nothing is dropped or repeated.
module lfu_page_replacement
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg                 i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PAGE_BITS-1:0] i_page,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output t_slot                o_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output t_fault               o_fault_count
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    // configuration
    t_cfg r_cfg;

    // input register
    logic                 r_in_valid;
    logic [PAGE_BITS-1:0] r_in_page;

    // frame state
    logic [PAGE_BITS-1:0]  r_page  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [COUNT_BITS-1:0] r_count [MAX_FRAMES];
    t_fault                r_faults;
    t_fault                n_faults;

    // result register
    logic                 r_out_valid;
    logic                 r_hit;
    t_slot                r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;
    t_fault               r_fault_out;

    logic                  advance;
    logic                  in_xfer;
    logic [7:0]            n_active;
    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] live;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      vic_idx;
    logic [IDX_W-1:0]      sel_idx;
    logic                  ev_valid;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [IDX_W+2:0]      slot_ext;

    // Advance the input register whenever the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Clamp frames_in_use to 1..MAX_FRAMES.
    always_comb begin
        if (i_rst_n && (r_cfg == '0)) begin
            n_active = 8'd1;
        end else if (8'(r_cfg) > 8'(MAX_FRAMES)) begin
            n_active = 8'(MAX_FRAMES);
        end else begin
            n_active = 8'(r_cfg);
        end
        if (n_active == 8'd0) begin
            n_active = 8'd1;
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            active[k] = 8'(k) < n_active;
        end
        live = active & r_valid;
    end

    lfu_match #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W)
    ) u_match (
        .i_page  (r_in_page),
        .i_pages (r_page),
        .i_live  (live),
        .o_hit   (hit),
        .o_idx   (hit_idx)
    );

    lfu_min_sel #(
        .MAX_FRAMES (MAX_FRAMES),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_min_sel (
        .i_counts (r_count),
        .i_active (active),
        .o_idx    (vic_idx)
    );

    assign sel_idx  = hit ? hit_idx : vic_idx;
    assign slot_ext = {3'b000, sel_idx};

    // Pick out the victim's contents with a one-hot AND-OR, and count a fault on a miss (saturating).
    always_comb begin
        ev_valid = 1'b0;
        ev_page  = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (vic_idx == IDX_W'(k)) begin
                ev_valid = ev_valid | r_valid[k];
                ev_page  = ev_page | (r_valid[k] ? r_page[k] : '0);
            end
        end
        n_faults = r_faults;
        if (!hit && (r_faults != FAULT_MAX)) begin
            n_faults = r_faults + t_fault'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_page <= i_page;
        end
    end

    // Frame update: bump the hit frame's count, or load the victim.
    genvar g;
    generate
        for (g = 0; g < MAX_FRAMES; g++) begin : g_frame
            logic sel_me;
            assign sel_me = (sel_idx == IDX_W'(g));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                    r_count[g] <= '0;
                end else if (advance && sel_me) begin
                    if (hit) begin
                        if (r_count[g] != '1) begin
                            r_count[g] <= r_count[g] + COUNT_BITS'(1);
                        end
                    end else begin
                        r_valid[g] <= 1'b1;
                        r_count[g] <= COUNT_BITS'(1);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (advance && sel_me && !hit) begin
                    r_page[g] <= r_in_page;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_faults    <= n_faults;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload while stalled; load it only on advance.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit       <= hit;
            r_slot      <= slot_ext[SLOT_W-1:0];
            r_ev_valid  <= !hit && ev_valid;
            r_ev_page   <= (!hit && ev_valid) ? ev_page : '0;
            r_fault_out <= n_faults;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_fault_out;

endmodule
